>>> sv/dppt_pkg.sv
// Shared types, register codes, reset values and helpers of the drum pad trigger.
package dppt_pkg;

	// default sizing
	localparam int PAD_COUNT_DEF  = 8;
	localparam int COUNT_BITS_DEF = 17;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 56;

	localparam logic [CFG_IDX_W-1:0] REG_THR_LO     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THR_HI     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_WIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_MAP   = 3'd4;

	localparam logic [47:0] THR_LO_RST   = 48'd13747251609800;
	localparam logic [47:0] THR_HI_RST   = 48'd27494502400200;
	localparam logic [15:0] SCAN_WIN_RST = 16'd100;
	localparam logic [15:0] DEBOUNCE_RST = 16'd1000;
	localparam logic [55:0] NOTE_MAP_RST = 56'd27309063235261220;

	// field widths
	localparam int PAD_W    = 3;
	localparam int SAMPLE_W = 12;
	localparam int NOTE_W   = 7;
	localparam int VEL_W    = 7;

	typedef struct packed {
		logic [47:0] thr_lo;
		logic [47:0] thr_hi;
		logic [15:0] scan_win;
		logic [15:0] debounce;
		logic [55:0] note_map;
	} cfg_regs_t;

	typedef struct packed {
		logic              hit;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  velocity;
	} hit_info_t;

	// floor(127 * peak / 4095): divide by 2^12-1 as (x + x/4096 + 1) / 4096
	function automatic logic [VEL_W-1:0] velocity_of(input logic [SAMPLE_W-1:0] peak);
		logic [19:0] x;
		logic [19:0] sum;
		x   = {1'b0, peak, 7'd0} - {8'd0, peak};
		sum = x + {12'd0, x[19:12]} + 20'd1;
		return sum[18:12];
	endfunction

endpackage

>>> sv/dppt_ifs.sv
// Request channels for incoming samples and outgoing hits.
interface dppt_sample_if;
	logic                          valid;
	logic                          ready;
	logic [dppt_pkg::PAD_W-1:0]    pad;
	logic [dppt_pkg::SAMPLE_W-1:0] sample;

	modport source(output valid, pad, sample, input ready);
	modport sink(input valid, pad, sample, output ready);
endinterface

interface dppt_hit_if;
	logic                        valid;
	logic                        ready;
	logic [dppt_pkg::PAD_W-1:0]  hit_pad;
	logic [dppt_pkg::NOTE_W-1:0] note;
	logic [dppt_pkg::VEL_W-1:0]  velocity;

	modport source(output valid, hit_pad, note, velocity, input ready);
	modport sink(input valid, hit_pad, note, velocity, output ready);
endinterface

>>> sv/dppt_cfg_regs.sv
// Configuration register file of the drum pad trigger.
module dppt_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              we,
	input  logic [dppt_pkg::CFG_IDX_W-1:0]    idx,
	input  logic [dppt_pkg::CFG_DATA_W-1:0]   wdata,
	output dppt_pkg::cfg_regs_t               regs
);

	dppt_pkg::cfg_regs_t regs_q;

	// decoded writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.thr_lo   <= dppt_pkg::THR_LO_RST;
			regs_q.thr_hi   <= dppt_pkg::THR_HI_RST;
			regs_q.scan_win <= dppt_pkg::SCAN_WIN_RST;
			regs_q.debounce <= dppt_pkg::DEBOUNCE_RST;
			regs_q.note_map <= dppt_pkg::NOTE_MAP_RST;
		end else if (we) begin
			case (idx)
				dppt_pkg::REG_THR_LO:   regs_q.thr_lo   <= wdata[47:0];
				dppt_pkg::REG_THR_HI:   regs_q.thr_hi   <= wdata[47:0];
				dppt_pkg::REG_SCAN_WIN: regs_q.scan_win <= wdata[15:0];
				dppt_pkg::REG_DEBOUNCE: regs_q.debounce <= wdata[15:0];
				dppt_pkg::REG_NOTE_MAP: regs_q.note_map <= wdata[55:0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

>>> sv/dppt_pad_ram.sv
// Per-pad state memory: one write port, one registered read port, valid bits per entry.
module dppt_pad_ram #(
	parameter int DEPTH  = dppt_pkg::PAD_COUNT_DEF,
	parameter int WIDTH  = 2 + dppt_pkg::COUNT_BITS_DEF + dppt_pkg::SAMPLE_W,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rdata_q;
	logic             rvalid_q;

	// storage write and registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	// entries read as zero until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we)
				valid_q[waddr] <= 1'b1;
			if (re)
				rvalid_q <= valid_q[raddr];
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

>>> sv/dppt_pad_update.sv
// Next-state and hit logic for one pad sample.
module dppt_pad_update #(
	parameter int COUNT_BITS = dppt_pkg::COUNT_BITS_DEF,
	parameter int STATE_W    = 2 + COUNT_BITS + dppt_pkg::SAMPLE_W
) (
	input  dppt_pkg::cfg_regs_t              cfg,
	input  logic [dppt_pkg::PAD_W-1:0]       pad,
	input  logic [dppt_pkg::SAMPLE_W-1:0]    sample,
	input  logic [STATE_W-1:0]               state_in,
	output logic [STATE_W-1:0]               state_out,
	output dppt_pkg::hit_info_t              result
);

	typedef struct packed {
		logic                          armed;
		logic                          scanning;
		logic [COUNT_BITS-1:0]         tick;
		logic [dppt_pkg::SAMPLE_W-1:0] peak;
	} pad_state_t;

	pad_state_t                    cur;
	pad_state_t                    nxt;
	logic [47:0]                   thr_word;
	logic [dppt_pkg::SAMPLE_W-1:0] thr;
	logic                          trig;
	logic                          scan_done;
	logic                          debounced;

	assign cur = state_in;

	// per-pad threshold lookup
	always_comb begin
		thr_word = pad[2] ? cfg.thr_hi : cfg.thr_lo;
		thr      = thr_word[12*pad[1:0] +: 12];
	end

	always_comb begin
		trig      = (sample > thr) && !cur.armed;
		scan_done = (32'(cur.tick) > 32'(cfg.scan_win)) && cur.scanning && cur.armed;
		debounced = 32'(cur.tick) > 32'(cfg.debounce);
		nxt       = cur;
		if (trig) begin
			// strike: arm and restart the scan
			nxt.armed    = 1'b1;
			nxt.scanning = 1'b1;
			nxt.tick     = '0;
			nxt.peak     = '0;
		end else begin
			if (cur.armed && cur.scanning && (sample > cur.peak))
				nxt.peak = sample;
			if (scan_done)
				nxt.scanning = 1'b0;
			if (debounced)
				nxt.armed = 1'b0;
			// saturating tick
			if (cur.tick != '1)
				nxt.tick = cur.tick + 1'b1;
		end
		result.note     = cfg.note_map[7*pad +: 7];
		result.hit      = !trig && scan_done;
		result.velocity = dppt_pkg::velocity_of(nxt.peak);
	end

	assign state_out = nxt;

endmodule

>>> sv/drum_pad_peak_trigger_unit.sv
// Top level of the multi-pad drum trigger with peak detection.
// Takes one sample per clock, for any mix of pads, including the same pad on
// consecutive cycles. Each sample is a read-modify-write of its pad's entry in
// the state memory: the read is issued when the sample is accepted, the update
// happens in the update stage and is written back when that stage advances,
// and a one-entry write-back forwarding register serves a sample whose pad was
// written at its read edge. A hit loads the output register as it advances.
// samples.ready drops only while a finished hit waits in the output register
// and the sample in the update stage produces another hit. The state memory
// holds a valid bit per pad, so it reads as cleared straight after reset with
// no clearing pass. Pad numbers at or above PAD_COUNT are ignored.
module drum_pad_peak_trigger_unit #(
	parameter int PAD_COUNT  = dppt_pkg::PAD_COUNT_DEF,
	parameter int COUNT_BITS = dppt_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dppt_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [dppt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	dppt_sample_if.sink                       samples,
	dppt_hit_if.source                        hits
);

	localparam int ADDR_W  = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
	localparam int STATE_W = 2 + COUNT_BITS + dppt_pkg::SAMPLE_W;

	dppt_pkg::cfg_regs_t           cfg;
	dppt_pkg::hit_info_t           upd_res;

	logic                          accept;
	logic                          stall;
	logic                          advance;
	logic                          hit_s1;
	logic                          we;
	logic [ADDR_W-1:0]             addr_s1;
	logic [STATE_W-1:0]            ram_rdata;
	logic [STATE_W-1:0]            cur_state;
	logic [STATE_W-1:0]            nxt_state;

	logic                          valid_s1;
	logic                          inrange_s1;
	logic [dppt_pkg::PAD_W-1:0]    pad_s1;
	logic [dppt_pkg::SAMPLE_W-1:0] sample_s1;

	logic                          fwd_vld_q;
	logic [ADDR_W-1:0]             fwd_addr_q;
	logic [STATE_W-1:0]            fwd_data_q;

	logic                          out_vld_q;
	logic [dppt_pkg::PAD_W-1:0]    out_pad_q;
	logic [dppt_pkg::NOTE_W-1:0]   out_note_q;
	logic [dppt_pkg::VEL_W-1:0]    out_vel_q;

	dppt_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_idx),
		.wdata  (cfg_wdata),
		.regs   (cfg)
	);

	// handshake control
	assign hit_s1         = valid_s1 && inrange_s1 && upd_res.hit;
	assign stall          = hit_s1 && out_vld_q && !hits.ready;
	assign advance        = valid_s1 && !stall;
	assign samples.ready  = !stall;
	assign accept         = samples.valid && samples.ready;
	assign addr_s1        = ADDR_W'(pad_s1);
	assign we             = advance && inrange_s1;

	// update stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (samples.ready)
			valid_s1 <= samples.valid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pad_s1     <= samples.pad;
			sample_s1  <= samples.sample;
			inrange_s1 <= int'(samples.pad) < PAD_COUNT;
		end
	end

	dppt_pad_ram #(
		.DEPTH  (PAD_COUNT),
		.WIDTH  (STATE_W),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we),
		.waddr  (addr_s1),
		.wdata  (nxt_state),
		.re     (accept),
		.raddr  (ADDR_W'(samples.pad)),
		.rdata  (ram_rdata)
	);

	// write-back forwarding: the read misses a write on its own edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fwd_vld_q <= 1'b0;
		else if (we)
			fwd_vld_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= nxt_state;
		end
	end

	assign cur_state = (fwd_vld_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : ram_rdata;

	dppt_pad_update #(
		.COUNT_BITS (COUNT_BITS),
		.STATE_W    (STATE_W)
	) u_upd (
		.cfg       (cfg),
		.pad       (pad_s1),
		.sample    (sample_s1),
		.state_in  (cur_state),
		.state_out (nxt_state),
		.result    (upd_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (advance && hit_s1)
			out_vld_q <= 1'b1;
		else if (hits.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && hit_s1) begin
			out_pad_q  <= pad_s1;
			out_note_q <= upd_res.note;
			out_vel_q  <= upd_res.velocity;
		end
	end

	assign hits.valid    = out_vld_q;
	assign hits.hit_pad  = out_pad_q;
	assign hits.note     = out_note_q;
	assign hits.velocity = out_vel_q;

	// checks
	a_hit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		advance && hit_s1 |-> !out_vld_q || hits.ready)
		else $error("hit issued into an occupied output register");

	a_ready_low_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> valid_s1 && hit_s1 && hits.valid)
		else $error("sample input stalled without a blocked hit");

	a_hit_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s1 |-> cur_state[STATE_W-1] && cur_state[STATE_W-2])
		else $error("hit from a pad that is not armed and scanning");

	a_ignored_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !inrange_s1 |-> !we && !hit_s1)
		else $error("out-of-range pad touched state");

endmodule
